### hdl/ntp_seconds_to_calendar_top_macros.svh
// assertion macros for the ntp seconds to calendar decoder
// expects a clock named clk and a synchronous reset named rst in the including module
`ifndef NTP_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`define NTP_SECONDS_TO_CALENDAR_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define NTPCAL_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define NTPCAL_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### hdl/ntpcal_pkg.sv
// types, constants and helpers for the ntp seconds to calendar decoder
// no dependencies
`default_nettype none

package ntpcal_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_SERVER  = 2'd1,
    ST_BEFORE_2013 = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  mode_bits;
    logic [31:0] transmit_seconds;
  } req_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [7:0]  year_since_1900;
    logic [2:0]  weekday;
  } rsp_item_t;

  localparam logic [2:0]  MODE_SERVER       = 3'd4;
  localparam logic [31:0] SECS_1900_TO_2013 = 32'd3565987200;
  localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR     = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN      = 6'd60;
  localparam logic [10:0] DAYS_PER_CYCLE    = 11'd1461;
  localparam logic [8:0]  DAYS_PER_YEAR     = 9'd365;
  localparam logic [2:0]  DAYS_PER_WEEK     = 3'd7;
  localparam logic [1:0]  BASE_WEEKDAY      = 2'd2;
  localparam int          BASE_YEAR         = 2013;
  localparam int          EPOCH_YEAR        = 1900;
  localparam logic [7:0]  YEAR_OFFSET       = 8'(BASE_YEAR - EPOCH_YEAR);

  // reciprocals, exact over the reachable input span
  // days     = ((elapsed >> 7) * DAY_RECIP) >> 33
  // q4       = (days * CYCLE_RECIP) >> 24
  // weeks    = (x * WEEK_RECIP) >> 16
  // hours    = ((sod >> 4) * HOUR_RECIP) >> 20
  // minutes  = ((ms >> 2) * MIN_RECIP) >> 14
  localparam logic [23:0] DAY_RECIP   = 24'd12725830;
  localparam logic [13:0] CYCLE_RECIP = 14'd11484;
  localparam logic [13:0] WEEK_RECIP  = 14'd9363;
  localparam logic [12:0] HOUR_RECIP  = 13'd4661;
  localparam logic [10:0] MIN_RECIP   = 11'd1093;

  // day of year on which a month starts, february stretched in a leap year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

### hdl/ntp_seconds_to_calendar_top.sv
// one item per cycle while the output is not stalled; register stages
// s0 to s5 and an output register hold the decode, which uses
// constant-reciprocal multiplies, each with its correction subtract
// a stalled output freezes every stage; reset clears all stage valid flags
// ntp transmit seconds to utc calendar decoder, depends on ntpcal_pkg
// and ntp_seconds_to_calendar_top_macros.svh
`default_nettype none

module ntp_seconds_to_calendar_top (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    req_valid,
  output logic                   req_ready,
  input  wire ntpcal_pkg::req_item_t req,
  output logic                   rsp_valid,
  input  wire                    rsp_ready,
  output ntpcal_pkg::rsp_item_t  rsp
);
  import ntpcal_pkg::*;

  `include "ntp_seconds_to_calendar_top_macros.svh"

  logic       advance;
  logic [5:0] stage_valid;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;

  // stage 0: input register
  logic [2:0]  s0_mode;
  logic [31:0] s0_secs;

  // stage 1: status, day count
  status_t     s1_status;
  logic [16:0] s1_elapsed_lo;
  logic [13:0] s1_days;

  // stage 2: second of day, four-year cycle, week count
  status_t     s2_status;
  logic [13:0] s2_days;
  logic [16:0] s2_sod;
  logic [2:0]  s2_q4;
  logic [10:0] s2_wq;

  // stage 3: hour, day within cycle, weekday
  status_t     s3_status;
  logic [16:0] s3_sod;
  logic [4:0]  s3_hour;
  logic [2:0]  s3_q4;
  logic [10:0] s3_r4;
  logic [2:0]  s3_wk;

  // stage 4: second of hour, year, day of year
  status_t     s4_status;
  logic [11:0] s4_ms;
  logic [4:0]  s4_hour;
  logic [8:0]  s4_doy;
  logic        s4_leap;
  logic [7:0]  s4_year;
  logic [2:0]  s4_wk;

  // stage 5: minute, month
  status_t     s5_status;
  logic [11:0] s5_ms;
  logic [5:0]  s5_min;
  logic [4:0]  s5_hour;
  logic [8:0]  s5_doy;
  logic        s5_leap;
  logic [3:0]  s5_month;
  logic [7:0]  s5_year;
  logic [2:0]  s5_wk;

  // ---- stage 1 logic
  status_t     status_next;
  logic [31:0] elapsed_full;
  logic [46:0] day_prod;

  always_comb begin
    if (s0_mode != MODE_SERVER) begin
      status_next = ST_NOT_SERVER;
    end else if (s0_secs < SECS_1900_TO_2013) begin
      status_next = ST_BEFORE_2013;
    end else begin
      status_next = ST_OK;
    end
  end

  assign elapsed_full = s0_secs - SECS_1900_TO_2013;
  assign day_prod     = 47'(elapsed_full[29:7]) * 47'(DAY_RECIP);

  // ---- stage 2 logic
  logic [30:0] day_secs;
  logic [16:0] sod_next;
  logic [27:0] cycle_prod;
  logic [13:0] week_in;
  logic [27:0] week_prod;

  assign day_secs   = 31'(s1_days) * 31'(SECS_PER_DAY);
  assign sod_next   = s1_elapsed_lo - day_secs[16:0];
  assign cycle_prod = 28'(s1_days) * 28'(CYCLE_RECIP);
  assign week_in    = s1_days + 14'(BASE_WEEKDAY);
  assign week_prod  = 28'(week_in) * 28'(WEEK_RECIP);

  // ---- stage 3 logic
  logic [25:0] hour_prod;
  logic [13:0] cycle_days;
  logic [13:0] r4_full;
  logic [13:0] wk_full;

  assign hour_prod  = 26'(s2_sod[16:4]) * 26'(HOUR_RECIP);
  assign cycle_days = 14'(s2_q4) * 14'(DAYS_PER_CYCLE);
  assign r4_full    = s2_days - cycle_days;
  assign wk_full    = (s2_days + 14'(BASE_WEEKDAY)) - 14'(s2_wq) * 14'(DAYS_PER_WEEK);

  // ---- stage 4 logic
  logic [16:0] hour_secs;
  logic [16:0] ms_full;
  logic [1:0]  year_in_cycle;
  logic [10:0] doy_full;
  logic [7:0]  year_next;

  assign hour_secs = 17'(s3_hour) * 17'(SECS_PER_HOUR);
  assign ms_full   = s3_sod - hour_secs;

  // cycle starts on a common year, the fourth year of each cycle is leap
  always_comb begin
    if (s3_r4 >= 11'(3 * DAYS_PER_YEAR)) begin
      year_in_cycle = 2'd3;
    end else if (s3_r4 >= 11'(2 * DAYS_PER_YEAR)) begin
      year_in_cycle = 2'd2;
    end else if (s3_r4 >= 11'(DAYS_PER_YEAR)) begin
      year_in_cycle = 2'd1;
    end else begin
      year_in_cycle = 2'd0;
    end
  end

  assign doy_full  = s3_r4 - 11'(year_in_cycle) * 11'(DAYS_PER_YEAR);
  assign year_next = YEAR_OFFSET + {3'd0, s3_q4, 2'b00} + {6'd0, year_in_cycle};

  // ---- stage 5 logic
  logic [20:0] min_prod;
  logic [3:0]  month_next;

  assign min_prod = 21'(s4_ms[11:2]) * 21'(MIN_RECIP);

  always_comb begin
    month_next = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s4_doy >= month_start(4'(m), s4_leap)) begin
        month_next = 4'(m);
      end
    end
  end

  // ---- output logic
  logic [11:0] min_secs;
  logic [11:0] sec_full;
  logic [8:0]  day_full;
  rsp_item_t   rsp_next;

  assign min_secs = 12'(s5_min) * 12'(SECS_PER_MIN);
  assign sec_full = s5_ms - min_secs;
  assign day_full = s5_doy - month_start(s5_month, s5_leap) + 9'd1;

  always_comb begin
    rsp_next        = '0;
    rsp_next.status = s5_status;
    if (s5_status == ST_OK) begin
      rsp_next.second_of_minute = sec_full[5:0];
      rsp_next.minute_of_hour   = s5_min;
      rsp_next.hour_of_day      = s5_hour;
      rsp_next.day_of_month     = day_full[4:0];
      rsp_next.month_index      = s5_month;
      rsp_next.year_since_1900  = s5_year;
      rsp_next.weekday          = s5_wk;
    end
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      rsp_valid   <= 1'b0;
    end else if (advance) begin
      stage_valid <= {stage_valid[4:0], req_valid};
      rsp_valid   <= stage_valid[5];
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_mode       <= req.mode_bits;
      s0_secs       <= req.transmit_seconds;

      s1_status     <= status_next;
      s1_elapsed_lo <= elapsed_full[16:0];
      s1_days       <= day_prod[46:33];

      s2_status     <= s1_status;
      s2_days       <= s1_days;
      s2_sod        <= sod_next;
      s2_q4         <= cycle_prod[26:24];
      s2_wq         <= week_prod[26:16];

      s3_status     <= s2_status;
      s3_sod        <= s2_sod;
      s3_hour       <= hour_prod[24:20];
      s3_q4         <= s2_q4;
      s3_r4         <= r4_full[10:0];
      s3_wk         <= wk_full[2:0];

      s4_status     <= s3_status;
      s4_ms         <= ms_full[11:0];
      s4_hour       <= s3_hour;
      s4_doy        <= doy_full[8:0];
      s4_leap       <= (year_in_cycle == 2'd3);
      s4_year       <= year_next;
      s4_wk         <= s3_wk;

      s5_status     <= s4_status;
      s5_ms         <= s4_ms;
      s5_min        <= min_prod[19:14];
      s5_hour       <= s4_hour;
      s5_doy        <= s4_doy;
      s5_leap       <= s4_leap;
      s5_month      <= month_next;
      s5_year       <= s4_year;
      s5_wk         <= s4_wk;

      rsp           <= rsp_next;
    end
  end

  // ---- assertions
  logic ok_result;
  logic rej_result;
  logic time_in_range;
  logic date_in_range;
  logic fields_clear;

  assign ok_result     = rsp_valid && rsp.status == ST_OK;
  assign rej_result    = rsp_valid && rsp.status != ST_OK;
  assign time_in_range = rsp.second_of_minute < 6'd60 && rsp.minute_of_hour < 6'd60 &&
                         rsp.hour_of_day < 5'd24 && rsp.weekday < 3'd7;
  assign date_in_range = rsp.month_index < 4'd12 && rsp.day_of_month != 5'd0 &&
                         rsp.year_since_1900 >= 8'd113 && rsp.year_since_1900 <= 8'd136;
  assign fields_clear  = rsp.second_of_minute == 6'd0 && rsp.minute_of_hour == 6'd0 &&
                         rsp.hour_of_day == 5'd0 && rsp.day_of_month == 5'd0 &&
                         rsp.month_index == 4'd0 && rsp.year_since_1900 == 8'd0 &&
                         rsp.weekday == 3'd0;

  `NTPCAL_ASSERT_SAME(a_time_range, ok_result, time_in_range, "time of day or weekday out of range")
  `NTPCAL_ASSERT_SAME(a_date_range, ok_result, date_in_range, "calendar date out of range")
  `NTPCAL_ASSERT_SAME(a_reject_zero, rej_result, fields_clear, "rejected item has nonzero fields")
  `NTPCAL_ASSERT_NEXT(a_stall_freeze, rsp_valid && !rsp_ready, $stable(stage_valid), "stall moved")

endmodule

`default_nettype wire

### bench/tb.sv
// self-checking bench for ntp_seconds_to_calendar_top: sntp seconds in, utc calendar date out
// holds its own calendar decoder and a scoreboard class; depends on ntpcal_pkg and the rtl only
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ntpcal_pkg::*;

  localparam int unsigned SECS_AT_2013 = 32'd3565987200;
  localparam int unsigned DAY_SECS     = 86400;
  localparam int unsigned LAST_DAY     = 8437;     // 2036-02-07, last day a 32-bit count reaches
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          CYCLE_LIMIT  = 400000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;
  int        cycle_count;

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    case (m)
      1: begin
        return is_leap_year(y) ? 29 : 28;
      end
      3, 5, 8, 10: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // days from 2013-01-01 to the first of january of year y
  function automatic int unsigned days_before_year(int unsigned y);
    int unsigned d;
    d = 0;
    for (int unsigned k = 2013; k < y; k++) d += is_leap_year(k) ? 366 : 365;
    return d;
  endfunction

  // seconds count for a day offset from 2013 and a second of day, clamped to 32 bits
  function automatic logic [31:0] secs_at(int unsigned day, int unsigned sod);
    longint unsigned s;
    s = longint'(SECS_AT_2013) + longint'(day) * DAY_SECS + sod;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    return s[31:0];
  endfunction

  class calendar_scoreboard;
    rsp_item_t pending_dates[$];
    int        error_count;

    function rsp_item_t decode_timestamp(req_item_t it);
      rsp_item_t   r;
      int unsigned elapsed, days, sod, year, month;
      r = '0;
      if (it.mode_bits != MODE_SERVER) begin
        r.status = ST_NOT_SERVER;
        return r;
      end
      if (it.transmit_seconds < SECS_AT_2013) begin
        r.status = ST_BEFORE_2013;
        return r;
      end
      elapsed   = it.transmit_seconds - SECS_AT_2013;
      days      = elapsed / DAY_SECS;
      sod       = elapsed % DAY_SECS;
      // 2013-01-01 was a tuesday
      r.weekday = 3'((days + 2) % 7);
      year = 2013;
      while (days >= (is_leap_year(year) ? 366 : 365)) begin
        days -= is_leap_year(year) ? 366 : 365;
        year++;
      end
      month = 0;
      while (month < 11 && days >= month_length(month, year)) begin
        days -= month_length(month, year);
        month++;
      end
      r.status           = ST_OK;
      r.second_of_minute = 6'(sod % 60);
      r.minute_of_hour   = 6'((sod % 3600) / 60);
      r.hour_of_day      = 5'(sod / 3600);
      r.day_of_month     = 5'(days + 1);
      r.month_index      = 4'(month);
      r.year_since_1900  = 8'(year - 1900);
      return r;
    endfunction

    function void note_request(req_item_t it);
      pending_dates.push_back(decode_timestamp(it));
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        error_count++;
      end
    endfunction

    function void check_date(rsp_item_t got);
      rsp_item_t want;
      if (pending_dates.size() == 0) begin
        $error("result item with no request pending");
        error_count++;
        return;
      end
      want = pending_dates.pop_front();
      check_field("status", want.status, got.status);
      check_field("second_of_minute", want.second_of_minute, got.second_of_minute);
      check_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
      check_field("hour_of_day", want.hour_of_day, got.hour_of_day);
      check_field("day_of_month", want.day_of_month, got.day_of_month);
      check_field("month_index", want.month_index, got.month_index);
      check_field("year_since_1900", want.year_since_1900, got.year_since_1900);
      check_field("weekday", want.weekday, got.weekday);
    endfunction
  endclass

  calendar_scoreboard calendar_sb = new();

  ntp_seconds_to_calendar_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ntp_seconds_to_calendar_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) calendar_sb.check_date(rsp);
  end

  // receiver: segments of free flow, random stalls, heavy stalls and a rotating mask
  initial begin
    int       seg_kind;
    int       seg_len;
    bit [7:0] mask;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      seg_kind = $urandom_range(0, 3);
      seg_len  = $urandom_range(4, 60);
      mask     = 8'($urandom);
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk);
        case (seg_kind)
          0: begin
            rsp_ready <= 1'b1;
          end
          1: begin
            rsp_ready <= 1'($urandom);
          end
          2: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            rsp_ready <= mask[k % 8];
          end
        endcase
      end
    end
  end

  task automatic send_request(input req_item_t it);
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    calendar_sb.note_request(it);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
      req       <= req_item_t'({$urandom, $urandom});
    end
  endtask

  function automatic req_item_t server_item(logic [31:0] secs);
    req_item_t it;
    it.mode_bits        = MODE_SERVER;
    it.transmit_seconds = secs;
    return it;
  endfunction

  function automatic req_item_t random_request();
    req_item_t   it;
    int          pick;
    int unsigned yr;
    int unsigned day;
    pick = $urandom_range(0, 99);
    it   = server_item($urandom_range(32'hFFFF_FFFF, SECS_AT_2013));
    if (pick >= 70 && pick < 80) begin
      // around day, year and leap-day boundaries
      if ($urandom_range(0, 1)) begin
        day = $urandom_range(0, LAST_DAY);
      end else begin
        yr  = $urandom_range(2013, 2036);
        day = days_before_year(yr);
        case ($urandom_range(0, 3))
          0: day = (day == 0) ? 0 : day - 1;
          1: day = day + 58;
          2: day = day + 59;
          default: ;
        endcase
      end
      case ($urandom_range(0, 2))
        0: it.transmit_seconds = secs_at(day, 0);
        1: it.transmit_seconds = secs_at(day, DAY_SECS - 1);
        default: it.transmit_seconds = secs_at(day, $urandom_range(0, DAY_SECS - 1));
      endcase
    end else if (pick >= 80 && pick < 90) begin
      it.transmit_seconds = $urandom;
    end else if (pick >= 90) begin
      it.mode_bits        = 3'($urandom);
      it.transmit_seconds = $urandom;
    end
    return it;
  endfunction

  initial begin
    req_item_t it;
    int        sent;
    int        burst;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every mode other than server, with assorted seconds
    for (int m = 0; m < 8; m++) begin
      if (m != MODE_SERVER) begin
        it.mode_bits        = 3'(m);
        it.transmit_seconds = (m % 2) ? 32'hFFFF_FFFF : secs_at(1154, 45296);
        send_request(it);
      end
    end
    send_request(server_item(32'd0));
    send_request(server_item(SECS_AT_2013 - 1));
    send_request(server_item(SECS_AT_2013));
    send_request(server_item(SECS_AT_2013 + 1));
    send_request(server_item(32'hFFFF_FFFF));
    // end of 2013, leap day 2016, end of a leap year, march after a leap february
    send_request(server_item(secs_at(364, DAY_SECS - 1)));
    send_request(server_item(secs_at(365, 0)));
    send_request(server_item(secs_at(1154, 45296)));
    send_request(server_item(secs_at(1460, DAY_SECS - 1)));
    send_request(server_item(secs_at(1461, 0)));
    send_request(server_item(secs_at(days_before_year(2020) + 60, 3600)));
    send_request(server_item(secs_at(days_before_year(2036) - 1, DAY_SECS - 1)));
    send_request(server_item(secs_at(days_before_year(2036), 0)));
    idle_cycles(DRAIN_CYCLES);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_request(random_request());
        sent++;
      end
      // mostly short gaps, now and then a long one that can let the pipeline empty
      if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(8, 20));
      else idle_cycles($urandom_range(0, 5));
    end
    idle_cycles(1);

    while (calendar_sb.pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (calendar_sb.error_count == 0) begin
      $display("ntp_seconds_to_calendar_top regression: pass");
    end else begin
      $display("ntp_seconds_to_calendar_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
